// File: hdl/half_float_channel_to_unorm_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef HALF_FLOAT_CHANNEL_TO_UNORM_ASSERT_SVH
`define HALF_FLOAT_CHANNEL_TO_UNORM_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HFCU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define HFCU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HFCU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define HFCU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: hdl/hfcu_pkg.sv
`timescale 1ns / 1ps
package hfcu_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SOURCE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET_KIND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DENORMALIZE = 2'd2;

    localparam logic [15:0] MAX_U8  = 16'h00FF;
    localparam logic [15:0] MAX_U16 = 16'hFFFF;

    localparam logic [4:0] EXP_ALL_ONES = 5'h1F;
    localparam logic [4:0] EXP_ZERO     = 5'h00;

    // 0.5 with 24 fraction bits, in the width of the rounding sum
    localparam logic [56:0] ROUND_HALF = 57'd8388608;

    typedef struct packed {
        logic source_kind;
        logic target_kind;
        logic denormalize;
    } t_cfg;

    typedef struct packed {
        logic [15:0] value;
        logic        clip;
    } t_conv;

    function automatic logic [15:0] target_max(input logic target_kind);
        return target_kind ? MAX_U16 : MAX_U8;
    endfunction

endpackage

// File: hdl/half_float_channel_to_unorm.sv
// Pipeline: each input transaction is captured in the input register, passes the
//   conversion logic and is held in the result register that drives the output.
// Throughput: one transaction per cycle; a full result register stalls the
//   input only when the input register is full too.
// Reset: synchronous, active low; clears pipeline valids and all config to 0.
`timescale 1ns / 1ps
`include "half_float_channel_to_unorm_assert.svh"
module half_float_channel_to_unorm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hfcu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // [31:0] channel_value
    input  logic                           s_axis_tlast,  // final_item
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,  // [15:0] channel_out
    output logic [0:0]                     m_axis_tuser,  // [0] clipped
    output logic                           m_axis_tlast   // final_out
);

    hfcu_pkg::t_cfg  cfg;
    hfcu_pkg::t_conv conv;

    logic        r_in_vld;
    logic [15:0] r_in_data;
    logic        r_in_last;
    logic        r_out_vld;
    logic [15:0] r_out_data;
    logic        r_out_clip;
    logic        r_out_last;

    logic        out_free;
    logic        advance;
    logic        in_take;

    hfcu_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hfcu_convert u_conv (
        .i_raw  (r_in_data),
        .i_cfg  (cfg),
        .o_conv (conv)
    );

    assign out_free      = !r_out_vld || m_axis_tready;
    assign advance       = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= s_axis_tdata[15:0];
            r_in_last <= s_axis_tlast;
        end
        if (advance) begin
            r_out_data <= conv.value;
            r_out_clip <= conv.clip;
            r_out_last <= r_in_last;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_clip;
    assign m_axis_tlast    = r_out_last;

    `HFCU_ASSERT_IMP(a_clip_saturates, i_clk, i_rst_n, r_out_vld && r_out_clip, (r_out_data == 16'd0) || (r_out_data == hfcu_pkg::target_max(cfg.target_kind)), "clipped result is neither zero nor max")
    `HFCU_ASSERT_IMP(a_u8_upper_zero, i_clk, i_rst_n, r_out_vld && !cfg.target_kind, r_out_data[15:8] == 8'd0, "8-bit result has nonzero upper byte")
    `HFCU_ASSERT_IMP(a_int_no_clip, i_clk, i_rst_n, r_out_vld && cfg.source_kind, !r_out_clip, "integer source raised clipped")
    `HFCU_ASSERT_NXT(a_stall_keeps_item, i_clk, i_rst_n, r_in_vld && !advance, r_in_vld, "input register dropped a stalled item")

endmodule

// File: hdl/hfcu_cfg_regs.sv
`timescale 1ns / 1ps
module hfcu_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hfcu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data,
    output hfcu_pkg::t_cfg                 o_cfg
);

    hfcu_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hfcu_pkg::CFG_IDX_SOURCE_KIND: r_cfg.source_kind <= i_cfg_data;
                hfcu_pkg::CFG_IDX_TARGET_KIND: r_cfg.target_kind <= i_cfg_data;
                hfcu_pkg::CFG_IDX_DENORMALIZE: r_cfg.denormalize <= i_cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

endmodule

// File: hdl/hfcu_convert.sv
`timescale 1ns / 1ps
module hfcu_convert (
    input  logic [15:0]    i_raw,
    input  hfcu_pkg::t_cfg i_cfg,
    output hfcu_pkg::t_conv o_conv
);

    logic        sign;
    logic [4:0]  ex;
    logic [9:0]  frac;
    logic [10:0] mant;
    logic [4:0]  sh;
    logic [26:0] scaled;
    logic [55:0] mag;
    logic [56:0] half_v;
    logic [56:0] sum;
    logic [32:0] q;
    logic [15:0] maxv;
    logic        over;

    always_comb begin
        sign = i_raw[15];
        ex   = i_raw[14:10];
        frac = i_raw[9:0];
        maxv = hfcu_pkg::target_max(i_cfg.target_kind);

        if (ex == hfcu_pkg::EXP_ZERO) begin
            mant = {1'b0, frac};
            sh   = 5'd0;
        end else begin
            mant = {1'b1, frac};
            sh   = ex - 5'd1;
        end

        // value * max as shift and subtract when denormalizing, else value * 1
        if (!i_cfg.denormalize) begin
            scaled = {16'd0, mant};
        end else if (i_cfg.target_kind) begin
            scaled = {mant, 16'd0} - {16'd0, mant};
        end else begin
            scaled = {8'd0, mant, 8'd0} - {16'd0, mant};
        end

        mag    = {29'd0, scaled} << sh;
        half_v = i_cfg.denormalize ? hfcu_pkg::ROUND_HALF : 57'd0;
        sum    = {1'b0, mag} + half_v;
        q      = sum[56:24];
        over   = (q[32:16] != 17'd0) || (q[15:0] > maxv);

        if (i_cfg.source_kind) begin
            o_conv.value = i_raw & maxv;
            o_conv.clip  = 1'b0;
        end else if (ex == hfcu_pkg::EXP_ALL_ONES) begin
            // infinity or NaN
            o_conv.value = ((frac != 10'd0) || sign) ? 16'd0 : maxv;
            o_conv.clip  = 1'b1;
        end else if (sign && (mant != 11'd0)) begin
            o_conv.value = 16'd0;
            o_conv.clip  = ({1'b0, mag} > half_v);
        end else if (over) begin
            o_conv.value = maxv;
            o_conv.clip  = 1'b1;
        end else begin
            o_conv.value = q[15:0];
            o_conv.clip  = 1'b0;
        end
    end

endmodule

// File: sim/unorm_result_checker.sv
`timescale 1ns / 1ps
module unorm_result_checker
    import hfcu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [31:0]          i_in_data,
    input  logic                 i_in_last,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [15:0]          i_out_data,
    input  logic [0:0]           i_out_user,
    input  logic                 i_out_last,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int FRAC_BITS = 24;

    typedef struct packed {
        logic [15:0] channel;
        logic        clipped;
        logic        last;
    } unorm_result_t;

    unorm_result_t results_due[$];
    t_cfg          cfg_shadow = '0;

    // Exact fixed-point decode of a half (or pass-through of an integer) to unorm.
    function automatic t_conv convert_channel(input logic [31:0] raw, input t_cfg cfg);
        logic [15:0] maxv;
        logic [63:0] round_bias;
        logic [63:0] gain;
        logic [63:0] mant;
        logic [63:0] mag;
        logic [63:0] quot;
        logic [4:0]  expo;
        logic [9:0]  frac;
        logic        neg;
        int          shift;
        t_conv       res;
        maxv = cfg.target_kind ? MAX_U16 : MAX_U8;
        if (cfg.source_kind) begin
            res.value = raw[15:0] & maxv;
            res.clip  = 1'b0;
            return res;
        end
        neg  = raw[15];
        expo = raw[14:10];
        frac = raw[9:0];
        round_bias = cfg.denormalize ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
        gain       = cfg.denormalize ? 64'(maxv) : 64'd1;
        if (expo == EXP_ALL_ONES) begin
            res.clip  = 1'b1;
            res.value = (frac != 10'd0 || neg) ? 16'd0 : maxv;
            return res;
        end
        if (expo == EXP_ZERO) begin
            mant  = 64'(frac);
            shift = 0;
        end else begin
            mant  = 64'({1'b1, frac});
            shift = int'(expo) - 1;
        end
        mag = (mant * gain) << shift;
        // negative nonzero magnitude: zero out, clip only if it lands below zero
        if (neg && mag != 64'd0) begin
            res.value = 16'd0;
            res.clip  = (mag > round_bias);
            return res;
        end
        quot = (mag + round_bias) >> FRAC_BITS;
        if (quot > 64'(maxv)) begin
            res.value = maxv;
            res.clip  = 1'b1;
        end else begin
            res.value = quot[15:0];
            res.clip  = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        unorm_result_t got;
        unorm_result_t want;
        t_conv         conv;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg_shadow = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDX_SOURCE_KIND: cfg_shadow.source_kind = i_cfg_data;
                    CFG_IDX_TARGET_KIND: cfg_shadow.target_kind = i_cfg_data;
                    CFG_IDX_DENORMALIZE: cfg_shadow.denormalize = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_data, i_out_user[0], i_out_last};
                if (results_due.size() == 0) begin
                    $error("unexpected result transaction: channel_out=%0h clipped=%0b",
                           got.channel, got.clipped);
                    errs++;
                end else begin
                    want = results_due.pop_front();
                    if (got.channel !== want.channel) begin
                        $error("channel_out mismatch: expected %0h, actual %0h",
                               want.channel, got.channel);
                        errs++;
                    end
                    if (got.clipped !== want.clipped) begin
                        $error("clipped mismatch: expected %0b, actual %0b",
                               want.clipped, got.clipped);
                        errs++;
                    end
                    if (got.last !== want.last) begin
                        $error("final_out mismatch: expected %0b, actual %0b",
                               want.last, got.last);
                        errs++;
                    end
                    o_checked <= o_checked + 1;
                end
            end
            if (i_in_valid && i_in_ready) begin
                conv = convert_channel(i_in_data, cfg_shadow);
                results_due.push_back('{conv.value, conv.clip, i_in_last});
            end
        end
        o_mismatches <= o_mismatches + errs;
        o_pending    <= results_due.size();
    end

endmodule

// File: sim/half_float_channel_to_unorm_test.sv
`timescale 1ns / 1ps
module half_float_channel_to_unorm_test;
    import hfcu_pkg::*;

    localparam int PHASE_ITEMS = 180;

    // halves around zero, subnormals, one, the finite limit, infinities and NaN
    localparam logic [31:0] HALF_PROBES [16] = '{
        32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_03FF,
        32'h0000_0400, 32'h0000_3800, 32'h0000_3C00, 32'h0000_3C01,
        32'h0000_7BFF, 32'h0000_7C00, 32'h0000_FC00, 32'h0000_7E00,
        32'h0000_FE01, 32'h0000_BC00, 32'h0000_8001, 32'hFFFF_3BFF
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_IDX_SOURCE_KIND;
    logic                 cfg_data    = 1'b0;
    logic                 in_valid    = 1'b0;
    logic [31:0]          in_data     = '0;
    logic                 in_last     = 1'b0;
    logic                 out_ready   = 1'b0;
    logic                 cfg_ready;
    logic                 in_ready;
    logic                 out_valid;
    logic [15:0]          out_data;
    logic [0:0]           out_user;
    logic                 out_last;

    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;
    int mismatches;
    int pending;
    int checked;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    half_float_channel_to_unorm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tlast  (in_last),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .m_axis_tuser  (out_user),
        .m_axis_tlast  (out_last)
    );

    unorm_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_out_user   (out_user),
        .i_out_last   (out_last),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_channel(input logic [31:0] value, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= value;
        in_last  <= last;
        do @(posedge i_clk); while (!in_ready);
        sent++;
    endtask

    // Hold the input until every pending result has come out, then let the pipe settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_config(input t_cfg setting);
        logic [CFG_IDX_W-1:0] idx [3];
        logic                 val [3];
        idx = '{CFG_IDX_SOURCE_KIND, CFG_IDX_TARGET_KIND, CFG_IDX_DENORMALIZE};
        val = '{setting.source_kind, setting.target_kind, setting.denormalize};
        drain_results();
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge i_clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_channel(input t_cfg setting);
        logic [31:0] raw;
        raw = $urandom();
        if (setting.source_kind) begin
            case ($urandom_range(3))
                0: raw = raw & 32'h0000_00FF;
                1: raw = raw & 32'h0000_FFFF;
                2: raw = raw | 32'hFFFF_0000;
                default: ;
            endcase
            return raw;
        end
        // steer the exponent toward zero, infinity, one and the target limits
        case ($urandom_range(9))
            0, 1: ;
            2: raw[14:10] = EXP_ZERO;
            3: raw[14:10] = EXP_ALL_ONES;
            4, 5, 6: raw[14:10] = 5'($urandom_range(16, 12));
            7, 8: raw[14:10] = 5'($urandom_range(30, 20));
            default: raw[14:10] = 5'($urandom_range(31));
        endcase
        if ($urandom_range(9) > 0) raw[15] = ($urandom_range(3) == 0);
        return raw;
    endfunction

    initial begin
        t_cfg setting;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: special half values with scaling into 8 bits, then unscaled into 16 bits, then integer pass-through
        program_config('{source_kind: 1'b0, target_kind: 1'b0, denormalize: 1'b1});
        foreach (HALF_PROBES[k]) send_channel(HALF_PROBES[k], k == 15);
        program_config('{source_kind: 1'b0, target_kind: 1'b1, denormalize: 1'b0});
        send_channel(32'h0000_5BF8, 1'b0);
        send_channel(32'h0000_7BFF, 1'b0);
        send_channel(32'hFFFF_7FFF, 1'b1);
        program_config('{source_kind: 1'b1, target_kind: 1'b1, denormalize: 1'b1});
        send_channel(32'hFFFF_FFFF, 1'b0);
        send_channel(32'h0000_0000, 1'b0);
        send_channel(32'h1234_5678, 1'b1);

        // random: every register setting, rotating through the flow-control profiles
        for (int p = 0; p < 8; p++) begin
            setting = t_cfg'(3'(p));
            program_config(setting);
            case ((p + p / 4) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_channel(random_channel(setting), $urandom_range(15) == 0);
        end

        idle_pct  = 0;
        stall_pct = 0;
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d channel values over all eight source/target/scaling settings,", sent);
        $display("with free, sender-idle, receiver-stall and mixed flow; %0d results compared.",
                 checked);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
